>>> src/additive_sine_oscillator_bank_defines.svh
// Assertion macros shared by the oscillator bank RTL.
`ifndef ADDITIVE_SINE_OSCILLATOR_BANK_DEFINES_SVH
`define ADDITIVE_SINE_OSCILLATOR_BANK_DEFINES_SVH

// Check that expr holds in the same cycle as cond.
`define ASOB_ASSERT_SAME(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Check that expr holds in the cycle after cond.
`define ASOB_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

>>> src/asob_pkg.sv
// Shared types, constants and sine table builder for the oscillator bank.
package asob_pkg;

    localparam int NUM_OSC      = 8;
    localparam int SINE_ENTRIES = 1024;
    localparam int QUEUE_DEPTH  = 2;

    localparam int OSC_AW  = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1;
    localparam int CNT_W   = $clog2(NUM_OSC + 1);
    localparam int SINE_W  = $clog2(SINE_ENTRIES);
    localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam int INDEX_W = 3;
    localparam int STEP_W  = 32;
    localparam int LEVEL_W = 15;
    localparam int CFG_W   = 4;

    localparam int FULL_SCALE = 32767;

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Command kinds, encoded as the func field
    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd_kind;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WALK,
        BK_DRAIN
    } t_back_state;

    typedef struct packed {
        t_cmd_kind            kind;
        logic [INDEX_W-1:0]   osc_index;
        logic [STEP_W-1:0]    step;
        logic [LEVEL_W-1:0]   level;
        logic [CNT_W-1:0]     count;
    } t_cmd;

    // Sine word: sign bit over a 15-bit magnitude
    typedef logic [SINE_ENTRIES-1:0][15:0] t_sine_rom;

    // Build the full-wave sine table in Q1.15 from a fixed-point series
    function automatic t_sine_rom sine_rom_build();
        t_sine_rom       rom;
        longint unsigned p;
        longint unsigned r;
        longint unsigned theta;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned mag;
        logic [1:0]      quad;
        int              k;
        for (k = 0; k < SINE_ENTRIES; k++) begin
            p     = (64'(k) << 32) / SINE_ENTRIES;
            quad  = p[31:30];
            r     = p & (Q30_ONE - 64'd1);
            if (quad[0]) begin
                r = Q30_ONE - r;
            end
            theta = (r * HALF_PI_Q30) >> 30;
            x2    = (theta * theta) >> 30;
            t     = Q30_ONE - (x2 / 110);
            t     = Q30_ONE - (((x2 * t) >> 30) / 72);
            t     = Q30_ONE - (((x2 * t) >> 30) / 42);
            t     = Q30_ONE - (((x2 * t) >> 30) / 20);
            t     = Q30_ONE - (((x2 * t) >> 30) / 6);
            s     = (theta * t) >> 30;
            mag   = (s * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
            if (mag > 64'(FULL_SCALE)) begin
                mag = 64'(FULL_SCALE);
            end
            rom[k] = {quad[1], mag[14:0]};
        end
        return rom;
    endfunction

endpackage

>>> src/additive_sine_oscillator_bank.sv
// Top level of the additive sine oscillator bank.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+------------------------------------------
//  command   | i_start / o_busy             | i_func, i_osc_index, i_phase_increment,
//            |                              | i_amplitude
//  config    | i_cfg_valid / o_cfg_ready    | i_cfg_data (active oscillator count)
//  result    | o_strobe (one-cycle pulse)   | o_sample, o_saturated
//
// A load transaction writes one oscillator entry. A tick transaction walks the N active
// oscillators (N is the limited active count) through the single oscillator lane: one
// oscillator per cycle through table read, scale and sum, then drains the lane. The
// sample strobes in the cycle after the drain. A two-entry command queue lets the front
// accept while the engine works; o_busy rises only when that queue is full.
// The result cannot be stalled. Synchronous reset clears count, entries and queue.
`include "additive_sine_oscillator_bank_defines.svh"

module additive_sine_oscillator_bank import asob_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic               i_func,
    input  logic [INDEX_W-1:0] i_osc_index,
    input  logic [STEP_W-1:0]  i_phase_increment,
    input  logic [LEVEL_W-1:0] i_amplitude,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_W-1:0]   i_cfg_data,
    output logic               o_strobe,
    output logic signed [15:0] o_sample,
    output logic               o_saturated
);

    t_cmd w_push_cmd;
    t_cmd w_head_cmd;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;

    // Accept and classify
    asob_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .i_func            (i_func),
        .i_osc_index       (i_osc_index),
        .i_phase_increment (i_phase_increment),
        .i_amplitude       (i_amplitude),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_data        (i_cfg_data),
        .o_cfg_ready       (o_cfg_ready),
        .i_queue_full      (w_full),
        .o_busy            (o_busy),
        .o_push            (w_push),
        .o_cmd             (w_push_cmd)
    );

    // Decouple front and engine
    asob_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .i_pop   (w_pop),
        .o_data  (w_head_cmd),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // Run loads and ticks
    asob_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!w_empty),
        .i_cmd       (w_head_cmd),
        .o_cmd_pop   (w_pop),
        .o_strobe    (o_strobe),
        .o_sample    (o_sample),
        .o_saturated (o_saturated)
    );

    `ASOB_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_strobe, !o_strobe, "double strobe")
    `ASOB_ASSERT_SAME(a_sample_range, i_clk, i_rst_n, o_strobe, o_sample != 16'sh8000, "bad sample")
    `ASOB_ASSERT_SAME(a_no_push_full, i_clk, i_rst_n, w_push, !w_full, "push into full queue")
    `ASOB_ASSERT_SAME(a_no_pop_empty, i_clk, i_rst_n, w_pop, !w_empty, "pop from empty queue")

endmodule

>>> src/asob_cmd_queue.sv
// Short command queue between the front end and the oscillator engine.
module asob_cmd_queue import asob_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_full,
    output logic o_empty
);

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed command
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> src/asob_front.sv
// Front end: accepts transactions, holds the active count, builds commands.
module asob_front import asob_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_func,
    input  logic [INDEX_W-1:0] i_osc_index,
    input  logic [STEP_W-1:0]  i_phase_increment,
    input  logic [LEVEL_W-1:0] i_amplitude,
    input  logic               i_cfg_valid,
    input  logic [CFG_W-1:0]   i_cfg_data,
    output logic               o_cfg_ready,
    input  logic               i_queue_full,
    output logic               o_busy,
    output logic               o_push,
    output t_cmd               o_cmd
);

    logic [CFG_W-1:0] r_active_count;
    logic             w_accept;
    logic             w_index_ok;
    logic [CNT_W-1:0] w_count;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = i_queue_full;
    assign w_accept    = i_start && !i_queue_full;
    assign w_index_ok  = (int'(i_osc_index) < NUM_OSC);

    // Hold the configured oscillator count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_active_count <= i_cfg_data;
        end
    end

    // Limit the count to the size of the bank
    always_comb begin
        if (int'(r_active_count) > NUM_OSC) begin
            w_count = CNT_W'(NUM_OSC);
        end else begin
            w_count = CNT_W'(r_active_count);
        end
    end

    // Classify: drop loads that address past the bank
    always_comb begin
        o_cmd.kind      = t_cmd_kind'(i_func);
        o_cmd.osc_index = i_osc_index;
        o_cmd.step      = i_phase_increment;
        o_cmd.level     = i_amplitude;
        o_cmd.count     = w_count;
        o_push          = w_accept && ((o_cmd.kind == CMD_TICK) || w_index_ok);
    end

endmodule

>>> src/asob_back.sv
// Oscillator engine: oscillator state, sine table and the summing pipeline.
module asob_back import asob_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  t_cmd               i_cmd,
    output logic               o_cmd_pop,
    output logic               o_strobe,
    output logic signed [15:0] o_sample,
    output logic               o_saturated
);

    localparam t_sine_rom SineRom = sine_rom_build();
    localparam logic signed [16:0] SumHi = 17'(FULL_SCALE);
    localparam logic signed [16:0] SumLo = -SumHi;

    t_back_state        r_state, n_state;
    logic [OSC_AW-1:0]  r_j, n_j;
    logic [CNT_W-1:0]   r_count, n_count;

    logic [STEP_W-1:0]  r_phase [NUM_OSC];
    logic [STEP_W-1:0]  r_step  [NUM_OSC];
    logic [LEVEL_W-1:0] r_level [NUM_OSC];

    logic [15:0]        r_rom_word;
    logic [LEVEL_W-1:0] r_lvl1;
    logic               r_v1;
    logic [14:0]        r_term;
    logic               r_neg2;
    logic               r_v2;
    logic signed [15:0] r_acc;
    logic               r_sat;
    logic               r_strobe;
    logic signed [15:0] r_sample;
    logic               r_sat_out;

    logic               w_issue;
    logic               w_load_wr;
    logic               w_tick_start;
    logic               w_emit;
    logic               w_last;
    logic [OSC_AW-1:0]  w_load_addr;
    logic [SINE_W-1:0]  w_rom_addr;
    logic [29:0]        w_prod;
    logic signed [16:0] w_acc_ext;
    logic signed [16:0] w_term_ext;
    logic signed [16:0] w_sum;

    assign w_last      = (CNT_W'(r_j) + CNT_W'(1) == r_count);
    assign w_load_addr = OSC_AW'(i_cmd.osc_index);
    assign w_rom_addr  = r_phase[r_j][STEP_W-1 -: SINE_W];

    // Sequence loads and oscillator walks
    always_comb begin
        n_state      = r_state;
        n_j          = r_j;
        n_count      = r_count;
        o_cmd_pop    = 1'b0;
        w_load_wr    = 1'b0;
        w_tick_start = 1'b0;
        w_issue      = 1'b0;
        w_emit       = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.kind == CMD_LOAD) begin
                        w_load_wr = 1'b1;
                    end else begin
                        w_tick_start = 1'b1;
                        n_count      = i_cmd.count;
                        n_j          = '0;
                        n_state      = (i_cmd.count == '0) ? BK_DRAIN : BK_WALK;
                    end
                end
            end
            BK_WALK: begin
                w_issue = 1'b1;
                if (w_last) begin
                    n_state = BK_DRAIN;
                end else begin
                    n_j = r_j + OSC_AW'(1);
                end
            end
            BK_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    w_emit  = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_j      <= '0;
            r_count  <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_j      <= n_j;
            r_count  <= n_count;
            r_v1     <= w_issue;
            r_v2     <= r_v1;
            r_strobe <= w_emit;
        end
    end

    // Load oscillator entries and advance phases as they are walked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_OSC; i++) begin
                r_phase[i] <= '0;
                r_step[i]  <= '0;
                r_level[i] <= '0;
            end
        end else begin
            if (w_load_wr) begin
                r_step[w_load_addr]  <= i_cmd.step;
                r_level[w_load_addr] <= i_cmd.level;
                r_phase[w_load_addr] <= '0;
            end
            if (w_issue) begin
                r_phase[r_j] <= r_phase[r_j] + r_step[r_j];
            end
        end
    end

    // Stage one: registered sine table read
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rom_word <= SineRom[w_rom_addr];
            r_lvl1     <= r_level[r_j];
        end
    end

    // Stage two: scale by amplitude, round half away from zero
    assign w_prod = 30'(r_rom_word[14:0]) * 30'(r_lvl1) + 30'd16384;

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_term <= w_prod[29:15];
            r_neg2 <= r_rom_word[15];
        end
    end

    // Stage three: add the term and clamp the running sum
    assign w_acc_ext  = {r_acc[15], r_acc};
    assign w_term_ext = {2'b00, r_term};
    assign w_sum      = r_neg2 ? (w_acc_ext - w_term_ext) : (w_acc_ext + w_term_ext);

    always_ff @(posedge i_clk) begin
        if (w_tick_start) begin
            r_acc <= '0;
            r_sat <= 1'b0;
        end else if (r_v2) begin
            if (w_sum > SumHi) begin
                r_acc <= SumHi[15:0];
                r_sat <= 1'b1;
            end else if (w_sum < SumLo) begin
                r_acc <= SumLo[15:0];
                r_sat <= 1'b1;
            end else begin
                r_acc <= w_sum[15:0];
            end
        end
    end

    // Hold the finished sample for its strobe cycle
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_sample  <= r_acc;
            r_sat_out <= r_sat;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_sample    = r_sample;
    assign o_saturated = r_sat_out;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

// Self-checking testbench for the additive sine oscillator bank.
import asob_pkg::*;

typedef struct {
    logic signed [15:0] sample;
    logic               saturated;
} t_sample;

// Predict samples from the accepted commands and score what the bank emits
class sample_scoreboard;
    bit [CFG_W-1:0]   osc_count;
    bit [STEP_W-1:0]  phase_acc[NUM_OSC];
    bit [STEP_W-1:0]  phase_step[NUM_OSC];
    bit [LEVEL_W-1:0] peak_level[NUM_OSC];
    bit [14:0]        sine_magnitude[SINE_ENTRIES];
    bit               sine_negative[SINE_ENTRIES];
    t_sample          expected_samples[$];
    int               error_count;

    function new();
        longint unsigned frac;
        longint unsigned ang;
        longint unsigned theta;
        longint unsigned x2;
        longint unsigned poly;
        longint unsigned s;
        longint unsigned mag;
        int unsigned     divisors[4];
        bit [1:0]        quadrant;
        divisors = '{72, 42, 20, 6};
        // Build the sine table from the fixed-point series, one quadrant folded
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            frac     = (64'(k) << 32) / SINE_ENTRIES;
            quadrant = frac[31:30];
            ang      = frac & (Q30_ONE - 64'd1);
            if (quadrant[0]) begin
                ang = Q30_ONE - ang;
            end
            theta = (ang * HALF_PI_Q30) >> 30;
            x2    = (theta * theta) >> 30;
            poly  = Q30_ONE - (x2 / 64'd110);
            foreach (divisors[d]) begin
                poly = Q30_ONE - (((x2 * poly) >> 30) / divisors[d]);
            end
            s   = (theta * poly) >> 30;
            mag = (s * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
            if (mag > 64'(FULL_SCALE)) begin
                mag = 64'(FULL_SCALE);
            end
            sine_magnitude[k] = mag[14:0];
            sine_negative[k]  = quadrant[1];
        end
        osc_count   = '0;
        error_count = 0;
        foreach (phase_acc[i]) begin
            phase_acc[i]  = '0;
            phase_step[i] = '0;
            peak_level[i] = '0;
        end
    endfunction

    function void set_count(bit [CFG_W-1:0] value);
        osc_count = value;
    endfunction

    // Walk the active oscillators and queue the clamped sum
    function void predict_tick();
        int          n;
        int          acc;
        int          term;
        bit          clipped;
        int unsigned tidx;
        t_sample     result;
        n       = (osc_count > NUM_OSC) ? NUM_OSC : int'(osc_count);
        acc     = 0;
        clipped = 1'b0;
        for (int j = 0; j < n; j++) begin
            tidx = int'((64'(phase_acc[j]) * SINE_ENTRIES) >> 32);
            term = int'((64'(sine_magnitude[tidx]) * 64'(peak_level[j]) + 64'd16384) >> 15);
            if (sine_negative[tidx]) begin
                term = -term;
            end
            acc += term;
            if (acc > FULL_SCALE) begin
                acc     = FULL_SCALE;
                clipped = 1'b1;
            end else if (acc < -FULL_SCALE) begin
                acc     = -FULL_SCALE;
                clipped = 1'b1;
            end
            phase_acc[j] = phase_acc[j] + phase_step[j];
        end
        result.sample    = 16'(acc);
        result.saturated = clipped;
        expected_samples.insert(expected_samples.size(), result);
    endfunction

    function void note_command(t_cmd_kind kind, bit [INDEX_W-1:0] idx,
                               bit [STEP_W-1:0] step, bit [LEVEL_W-1:0] amp);
        if (kind == CMD_TICK) begin
            predict_tick();
        end else if (idx < NUM_OSC) begin
            phase_step[idx] = step;
            peak_level[idx] = amp;
            phase_acc[idx]  = '0;
        end
    endfunction

    function void check_result(logic signed [15:0] sample, logic saturated);
        t_sample want;
        if (expected_samples.size() == 0) begin
            $error("sample %0d emitted with no tick transaction pending", sample);
            error_count++;
            return;
        end
        want = expected_samples.pop_front();
        if (sample !== want.sample) begin
            $error("sample mismatch: expected %0d, actual %0d", want.sample, sample);
            error_count++;
        end
        if (saturated !== want.saturated) begin
            $error("saturated mismatch: expected %0b, actual %0b", want.saturated, saturated);
            error_count++;
        end
    endfunction

    function int pending();
        return expected_samples.size();
    endfunction
endclass

module tb_top;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 32;
    localparam int PHASES        = 14;
    localparam int PHASE_ITEMS   = 125;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic               i_func;
    logic [INDEX_W-1:0] i_osc_index;
    logic [STEP_W-1:0]  i_phase_increment;
    logic [LEVEL_W-1:0] i_amplitude;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               o_strobe;
    logic signed [15:0] o_sample;
    logic               o_saturated;

    sample_scoreboard sb = new();
    int unsigned      cycle_count = 0;

    additive_sine_oscillator_bank DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_func            (i_func),
        .i_osc_index       (i_osc_index),
        .i_phase_increment (i_phase_increment),
        .i_amplitude       (i_amplitude),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_strobe          (o_strobe),
        .o_sample          (o_sample),
        .o_saturated       (o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Score each strobed sample
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            sb.check_result(o_sample, o_saturated);
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("additive_sine_oscillator_bank test failed");
            $finish;
        end
    end

    // Issue one command transaction, then drop i_start and idle when gap is nonzero
    task automatic send_command(t_cmd_kind kind, bit [INDEX_W-1:0] idx,
                                bit [STEP_W-1:0] step, bit [LEVEL_W-1:0] amp, int gap);
        @(negedge i_clk);
        i_start           <= 1'b1;
        i_func            <= kind;
        i_osc_index       <= idx;
        i_phase_increment <= step;
        i_amplitude       <= amp;
        do @(posedge i_clk); while (o_busy);
        sb.note_command(kind, idx, step, amp);
        if (gap > 0) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Hold off commands until every sample is in and the engine has settled
    task automatic wait_drained();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(bit [CFG_W-1:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_count(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        bit [STEP_W-1:0]  dir_steps[NUM_OSC];
        bit [STEP_W-1:0]  step;
        bit [LEVEL_W-1:0] amp;
        t_cmd_kind        kind;
        bit               burst;
        int               drain_point;
        int               gap;

        dir_steps = '{32'h4000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                      32'h0000_0001, 32'h0040_0000, 32'h1234_5678, 32'hC000_0000};

        i_rst_n           = 1'b0;
        i_start           = 1'b0;
        i_func            = CMD_LOAD;
        i_osc_index       = '0;
        i_phase_increment = '0;
        i_amplitude       = '0;
        i_cfg_valid       = 1'b0;
        i_cfg_data        = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero active count gives a silent sample
        send_command(CMD_TICK, 3'd0, '0, '0, $urandom_range(0, 3));
        send_command(CMD_TICK, 3'd5, '1, '1, $urandom_range(0, 3));

        // Full bank at full scale, with zero and minimum amplitudes mixed in
        write_count(4'(NUM_OSC));
        for (int i = 0; i < NUM_OSC; i++) begin
            amp = (i == 3) ? 15'd0 : (i == 4) ? 15'd1 : 15'h7FFF;
            send_command(CMD_LOAD, 3'(i), dir_steps[i], amp, $urandom_range(0, 3));
        end
        repeat (4) send_command(CMD_TICK, '0, '0, '0, $urandom_range(0, 3));

        // Count above the bank size walks the whole bank
        write_count(4'hF);
        repeat (3) send_command(CMD_TICK, '0, '0, '0, $urandom_range(0, 3));

        // Quarter-cycle steps on one oscillator hit zero, peak and trough
        write_count(4'd1);
        send_command(CMD_LOAD, 3'd0, 32'h4000_0000, 15'h7FFF, $urandom_range(0, 3));
        repeat (4) send_command(CMD_TICK, '0, '0, '0, $urandom_range(0, 3));

        // Idle oscillators must have kept their phase
        write_count(4'd3);
        repeat (2) send_command(CMD_TICK, '0, '0, '0, $urandom_range(0, 3));

        // Random phases, each under its own active count
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       write_count(4'(NUM_OSC));
                1:       write_count(4'd0);
                2:       write_count(4'hF);
                3:       write_count(4'd1);
                default: write_count(4'($urandom_range(0, 15)));
            endcase
            burst       = ($urandom_range(0, 3) == 0);
            drain_point = $urandom_range(0, PHASE_ITEMS - 1);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == drain_point && ph % 2 == 0) begin
                    wait_drained();
                end
                kind = ($urandom_range(0, 9) < 7) ? CMD_TICK : CMD_LOAD;
                case ($urandom_range(0, 6))
                    0:       step = 32'($urandom_range(0, 32'h00FF_FFFF));
                    1:       step = '0;
                    2:       step = '1;
                    3:       step = {2'($urandom_range(0, 3)), 30'd0};
                    default: step = $urandom;
                endcase
                case ($urandom_range(0, 5))
                    0:       amp = 15'h7FFF;
                    1:       amp = '0;
                    2:       amp = 15'($urandom_range(0, 2000));
                    3:       amp = 15'($urandom_range(20000, 32767));
                    default: amp = 15'($urandom);
                endcase
                gap = burst ? 0 : $urandom_range(0, 13);
                send_command(kind, 3'($urandom_range(0, 7)), step, amp, gap);
            end
        end

        wait_drained();
        if (sb.error_count == 0 && sb.pending() == 0) begin
            $display("additive_sine_oscillator_bank test passed");
        end else begin
            $display("additive_sine_oscillator_bank test failed");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+src
src/asob_pkg.sv
src/asob_cmd_queue.sv
src/asob_front.sv
src/asob_back.sv
src/additive_sine_oscillator_bank.sv
tb/tb_top.sv
